FILE: src/ova_pkg.sv
// Shared constants, types and register indexes for the obstacle avoidance sequencer.
`default_nettype none
package ova_pkg;

  // Sensor and drive constants
  localparam int TICKS_PER_CM = 58;
  localparam int MIN_CM       = 2;
  localparam int MAX_CM       = 200;
  localparam int MAX_DRIVE    = 100;
  localparam int TURN_SPAN    = 2;

  // Reciprocals for exact floor division of narrow values by a constant
  localparam longint unsigned RECIP_CM_L =
      ((64'd1 << 32) + 64'(TICKS_PER_CM) - 64'd1) / 64'(TICKS_PER_CM);
  localparam logic [32:0] RECIP_CM = 33'(RECIP_CM_L);
  localparam longint unsigned RECIP_SPAN_L =
      ((64'd1 << 16) + 64'(TURN_SPAN) - 64'd1) / 64'(TURN_SPAN);
  localparam logic [16:0] RECIP_SPAN = 17'(RECIP_SPAN_L);
  localparam logic [8:0]  SPAN_W     = 9'(TURN_SPAN);
  localparam logic [15:0] MIN_CM_W   = 16'(MIN_CM);
  localparam logic [15:0] MAX_CM_W   = 16'(MAX_CM);

  localparam logic signed [23:0] DRIVE_LIM = 24'(MAX_DRIVE * 256);

  // Configuration register indexes
  localparam logic [2:0] REG_DANGER   = 3'd0;
  localparam logic [2:0] REG_INTERVAL = 3'd1;
  localparam logic [2:0] REG_STOP     = 3'd2;
  localparam logic [2:0] REG_BACK     = 3'd3;
  localparam logic [2:0] REG_TURN     = 3'd4;
  localparam logic [2:0] REG_GAIN_P   = 3'd5;
  localparam logic [2:0] REG_GAIN_I   = 3'd6;
  localparam logic [2:0] REG_GAIN_D   = 3'd7;

  // Register reset values
  localparam logic [7:0]  DANGER_RST   = 8'd20;
  localparam logic [15:0] INTERVAL_RST = 16'd50;
  localparam logic [15:0] STOP_RST     = 16'd1000;
  localparam logic [15:0] BACK_RST     = 16'd2000;
  localparam logic [15:0] TURN_RST     = 16'd1000;
  localparam logic [15:0] GAIN_P_RST   = 16'd10273;
  localparam logic [15:0] GAIN_I_RST   = 16'd36004;
  localparam logic [15:0] GAIN_D_RST   = 16'd5928;

  typedef enum logic [2:0] {
    MODE_INIT = 3'd0,
    MODE_MOVE = 3'd1,
    MODE_STOP = 3'd2,
    MODE_BACK = 3'd3,
    MODE_TURN = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    MOTOR_NONE  = 3'd0,
    MOTOR_FWD   = 3'd1,
    MOTOR_STOP  = 3'd2,
    MOTOR_BACK  = 3'd3,
    MOTOR_LEFT  = 3'd4,
    MOTOR_RIGHT = 3'd5
  } motor_t;

  typedef enum logic [2:0] {
    REP_FWD   = 3'd0,
    REP_STOP  = 3'd1,
    REP_BACK  = 3'd2,
    REP_LEFT  = 3'd3,
    REP_RIGHT = 3'd4
  } rep_t;

endpackage
`default_nettype wire

FILE: src/ova_pid.sv
// PID drive with leaky integral: Q16.16 state, Q.8 outputs, upper clamp.
`default_nettype none
module ova_pid
  import ova_pkg::*;
(
  input  wire logic signed [8:0]  err,
  input  wire logic signed [8:0]  prev_err,
  input  wire logic signed [31:0] integ,
  input  wire logic [7:0]         danger,
  input  wire logic [15:0]        gain_p,
  input  wire logic [15:0]        gain_i,
  input  wire logic [15:0]        gain_d,
  output logic signed [31:0]      integ_next,
  output logic signed [23:0]      speed,
  output logic signed [23:0]      drive
);

  localparam logic signed [33:0] ACC_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] ACC_MIN = -34'sh0_8000_0000;
  localparam logic signed [25:0] SPD_MAX = 26'sd8388607;
  localparam logic signed [25:0] SPD_MIN = -26'sd8388608;

  logic               clear;
  logic signed [33:0] base;
  logic signed [33:0] acc_wide;
  logic signed [31:0] acc;
  logic signed [48:0] iprod;
  logic signed [16:0] gp_s, gi_s, gd_s;
  logic signed [9:0]  diff;
  logic signed [25:0] pprod;
  logic signed [26:0] dprod;
  logic signed [33:0] sum;
  logic signed [25:0] sum_sh;

  assign gp_s = $signed({1'b0, gain_p});
  assign gi_s = $signed({1'b0, gain_i});
  assign gd_s = $signed({1'b0, gain_d});

  // Drop the integral when on target or far clear of the threshold
  assign clear = (err == 9'sd0) || ($signed({err[8], err}) > $signed({2'b00, danger}));
  assign base  = clear ? 34'sd0 : {{2{integ[31]}}, integ};
  assign acc_wide = base + $signed({{9{err[8]}}, err, 16'h0000});

  always_comb begin
    if (acc_wide > ACC_MAX) begin
      acc = ACC_MAX[31:0];
    end else if (acc_wide < ACC_MIN) begin
      acc = ACC_MIN[31:0];
    end else begin
      acc = acc_wide[31:0];
    end
  end

  assign iprod      = acc * gi_s;
  assign integ_next = iprod[47:16];

  assign diff  = $signed({err[8], err}) - $signed({prev_err[8], prev_err});
  assign pprod = err * gp_s;
  assign dprod = diff * gd_s;
  assign sum   = $signed({{8{pprod[25]}}, pprod}) + $signed({{7{dprod[26]}}, dprod})
               + $signed({{2{integ_next[31]}}, integ_next});
  assign sum_sh = sum[33:8];

  always_comb begin
    if (sum_sh > SPD_MAX) begin
      speed = SPD_MAX[23:0];
    end else if (sum_sh < SPD_MIN) begin
      speed = SPD_MIN[23:0];
    end else begin
      speed = sum_sh[23:0];
    end
  end

  assign drive = (speed > DRIVE_LIM) ? DRIVE_LIM : speed;

endmodule
`default_nettype wire

FILE: src/obstacle_avoid_sequencer_pid_top.sv
// Top level: stream ports, config registers, distance filter, mode machine, PID.
// Path: an input transfer goes into the input register and then into the result
// register, which holds it on the master port until its transfer completes.
// Throughput: one item per cycle while the master side does not stall; the input register captures
// the converted echo width; state, mode machine and PID update in the single stage behind it.
// Reset (synchronous, rst high): mode to init, all state cleared, registers
// back to their defaults, both stream stages empty.
`default_nettype none
module obstacle_avoid_sequencer_pid_top
  import ova_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // echo_ticks[15:0], now_ms[47:16], turn_pick[55:48]
  input  wire logic [0:0]  s_axis_tuser,  // echo_valid[0]
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // motor_cmd[2:0], drive[26:3], report_code[29:27],
                                          // speed_value[53:30], mode[56:54], zero fill
  output logic [1:0]       m_axis_tuser,  // report_valid[0], speed_valid[1]
  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers; always ready; unchecked by the block, the user must see they are written only while idle
  // ---------------------------------------------------------------------
  logic [7:0]  danger;
  logic [15:0] interval, stop_ms, back_ms, turn_ms, gain_p, gain_i, gain_d;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      danger   <= DANGER_RST;
      interval <= INTERVAL_RST;
      stop_ms  <= STOP_RST;
      back_ms  <= BACK_RST;
      turn_ms  <= TURN_RST;
      gain_p   <= GAIN_P_RST;
      gain_i   <= GAIN_I_RST;
      gain_d   <= GAIN_D_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DANGER:   danger   <= cfg_data[7:0];
        REG_INTERVAL: interval <= cfg_data;
        REG_STOP:     stop_ms  <= cfg_data;
        REG_BACK:     back_ms  <= cfg_data;
        REG_TURN:     turn_ms  <= cfg_data;
        REG_GAIN_P:   gain_p   <= cfg_data;
        REG_GAIN_I:   gain_i   <= cfg_data;
        REG_GAIN_D:   gain_d   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: a full input register feeds the result register; advance when the
  // result register is empty or its transfer completes this cycle
  // ---------------------------------------------------------------------
  logic in_valid;
  logic out_valid;
  logic advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // ---------------------------------------------------------------------
  // Input stage: echo width to cm through a reciprocal multiply, range
  // check, and turn side from the random pick
  // ---------------------------------------------------------------------
  logic [15:0] echo_ticks;
  logic [31:0] now_in;
  logic [7:0]  turn_pick;
  logic [48:0] cm_prod;
  logic [15:0] cm;
  logic        cm_ok;
  logic [24:0] pick_prod;
  logic [8:0]  pick_q;
  logic [17:0] pick_back;
  logic        pick_right;

  assign echo_ticks = s_axis_tdata[15:0];
  assign now_in     = s_axis_tdata[47:16];
  assign turn_pick  = s_axis_tdata[55:48];

  assign cm_prod = {33'd0, echo_ticks} * {16'd0, RECIP_CM};
  assign cm      = cm_prod[47:32];
  assign cm_ok   = s_axis_tuser[0] && (cm >= MIN_CM_W) && (cm <= MAX_CM_W);

  // Nonzero remainder of the pick picks a right turn
  assign pick_prod  = {17'd0, turn_pick} * {8'd0, RECIP_SPAN};
  assign pick_q     = {1'b0, pick_prod[23:16]};
  assign pick_back  = {9'd0, pick_q} * {9'd0, SPAN_W};
  assign pick_right = pick_back != {10'd0, turn_pick};

  logic [7:0]  in_dist;
  logic        in_dist_ok;
  logic [31:0] in_now;
  logic        in_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_dist    <= cm[7:0];
      in_dist_ok <= cm_ok;
      in_now     <= now_in;
      in_right   <= pick_right;
    end
  end

  // ---------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------
  mode_t              mode, mode_next;
  logic [31:0]        last_step, last_step_next;
  logic [31:0]        mode_start, mode_start_next;
  logic               reported, reported_next;
  logic               go_right, go_right_next;
  logic [7:0]         held, held_next;
  logic [8:0]         pair_sum, pair_sum_next;
  logic               pair_cnt, pair_cnt_next;
  logic signed [31:0] integ, integ_next;
  logic signed [8:0]  prev_err, prev_err_next;

  // Pair averaging: every second in-range reading sets the held distance
  logic [8:0] pair_add;

  assign pair_add = pair_sum + {1'b0, in_dist};

  always_comb begin
    held_next     = held;
    pair_sum_next = pair_sum;
    pair_cnt_next = pair_cnt;
    if (in_dist_ok) begin
      if (pair_cnt) begin
        held_next     = pair_add[8:1];
        pair_sum_next = 9'd0;
        pair_cnt_next = 1'b0;
      end else begin
        pair_sum_next = pair_add;
        pair_cnt_next = 1'b1;
      end
    end
  end

  // Step timing with wrapping millisecond arithmetic
  logic [31:0]       since_step;
  logic [31:0]       elapsed;
  logic              step;
  logic              near;
  logic signed [8:0] err;

  assign since_step = in_now - last_step;
  assign elapsed    = in_now - mode_start;
  assign step       = since_step >= {16'd0, interval};
  assign near       = held_next <= danger;
  assign err        = $signed({1'b0, held_next}) - $signed({1'b0, danger});

  logic signed [31:0] pid_integ;
  logic signed [23:0] pid_speed;
  logic signed [23:0] pid_drive;

  ova_pid u_pid (
    .err        (err),
    .prev_err   (prev_err),
    .integ      (integ),
    .danger     (danger),
    .gain_p     (gain_p),
    .gain_i     (gain_i),
    .gain_d     (gain_d),
    .integ_next (pid_integ),
    .speed      (pid_speed),
    .drive      (pid_drive)
  );

  // Mode machine: next state
  always_comb begin
    mode_next       = mode;
    last_step_next  = last_step;
    mode_start_next = mode_start;
    reported_next   = reported;
    go_right_next   = go_right;
    integ_next      = integ;
    prev_err_next   = prev_err;
    if (step) begin
      last_step_next = in_now;
      case (mode)
        MODE_MOVE: begin
          integ_next    = pid_integ;
          prev_err_next = err;
          if (near) begin
            mode_next       = MODE_STOP;
            mode_start_next = in_now;
            reported_next   = 1'b0;
          end else begin
            reported_next   = 1'b1;
          end
        end
        MODE_STOP: begin
          reported_next = 1'b1;
          if (elapsed >= {16'd0, stop_ms}) begin
            mode_next       = MODE_BACK;
            mode_start_next = in_now;
            reported_next   = 1'b0;
          end
        end
        MODE_BACK: begin
          reported_next = 1'b1;
          if (elapsed >= {16'd0, back_ms}) begin
            mode_next       = MODE_TURN;
            mode_start_next = in_now;
            go_right_next   = in_right;
            reported_next   = 1'b0;
          end
        end
        MODE_TURN: begin
          // Abort the turn on an obstacle; keep start time and report flag
          if (near) begin
            mode_next = MODE_STOP;
          end else begin
            reported_next = 1'b1;
            if (elapsed >= {16'd0, turn_ms}) begin
              mode_next       = MODE_INIT;
              mode_start_next = in_now;
              reported_next   = 1'b0;
            end
          end
        end
        default: begin
          mode_next = MODE_MOVE;
        end
      endcase
    end
  end

  // Mode machine: result fields
  motor_t             motor;
  logic               rep_valid;
  rep_t               rep_code;
  logic               spd_valid;
  logic signed [23:0] spd_value;
  logic signed [23:0] drive;

  always_comb begin
    motor     = MOTOR_NONE;
    rep_valid = 1'b0;
    rep_code  = REP_FWD;
    spd_valid = 1'b0;
    spd_value = 24'sd0;
    drive     = 24'sd0;
    if (step) begin
      case (mode)
        MODE_MOVE: begin
          spd_valid = 1'b1;
          spd_value = pid_speed;
          if (!near) begin
            motor     = MOTOR_FWD;
            drive     = pid_drive;
            rep_valid = !reported;
            rep_code  = REP_FWD;
          end
        end
        MODE_STOP: begin
          motor     = MOTOR_STOP;
          rep_valid = !reported;
          rep_code  = REP_STOP;
        end
        MODE_BACK: begin
          motor     = MOTOR_BACK;
          rep_valid = !reported;
          rep_code  = REP_BACK;
        end
        MODE_TURN: begin
          if (!near) begin
            motor     = go_right ? MOTOR_RIGHT : MOTOR_LEFT;
            rep_valid = !reported;
            rep_code  = go_right ? REP_RIGHT : REP_LEFT;
          end
        end
        default: ;
      endcase
    end
    // Report code reads zero whenever no report goes out
    if (!rep_valid) begin
      rep_code = REP_FWD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_INIT;
      last_step  <= 32'd0;
      mode_start <= 32'd0;
      reported   <= 1'b0;
      go_right   <= 1'b0;
      held       <= 8'd0;
      pair_sum   <= 9'd0;
      pair_cnt   <= 1'b0;
      integ      <= 32'sd0;
      prev_err   <= 9'sd0;
    end else if (advance) begin
      mode       <= mode_next;
      last_step  <= last_step_next;
      mode_start <= mode_start_next;
      reported   <= reported_next;
      go_right   <= go_right_next;
      held       <= held_next;
      pair_sum   <= pair_sum_next;
      pair_cnt   <= pair_cnt_next;
      integ      <= integ_next;
      prev_err   <= prev_err_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: hold until the master-side transfer completes
  // ---------------------------------------------------------------------
  logic [63:0] out_data;
  logic [1:0]  out_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {7'd0, mode_next, spd_value, rep_code, drive, motor};
      out_user <= {spd_valid, rep_valid};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

endmodule
`default_nettype wire

FILE: bench/ova_checker.sv
// Checker for the obstacle avoidance sequencer: predicts each pass result and compares it.
module ova_checker
  import ova_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // echo_ticks[15:0], now_ms[47:16], turn_pick[55:48]
  input  logic [0:0]  s_axis_tuser,  // echo_valid[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,  // motor_cmd[2:0], drive[26:3], report_code[29:27],
                                     // speed_value[53:30], mode[56:54], zero fill
  input  logic [1:0]  m_axis_tuser,  // report_valid[0], speed_valid[1]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ACC_HI   = 64'sd2147483647;
  localparam longint ACC_LO   = -64'sd2147483648;
  localparam longint SPEED_HI = 64'sd8388607;
  localparam longint SPEED_LO = -64'sd8388608;

  typedef struct packed {
    motor_t      motor;
    logic [23:0] drive;
    logic        rep_v;
    logic [2:0]  rep_c;
    logic        spd_v;
    logic [23:0] speed;
    mode_t       mode;
  } pass_result_t;

  pass_result_t expected_q[$];

  // Register copies
  logic [7:0]  danger_cm;
  logic [15:0] interval_ms, stop_hold_ms, back_hold_ms, turn_hold_ms;
  logic [15:0] kp, ki, kd;

  // Sequencer and filter state
  mode_t       mode_q;
  logic [31:0] last_step, mode_start;
  logic        reported, go_right;
  logic [7:0]  held_cm;
  logic [8:0]  pair_sum;
  logic        pair_half;
  int          integ;
  int          prev_err;

  // One PID update; returns the clamped drive and hands back the speed, clamped to its 24-bit range.
  function automatic longint pid_drive(output longint speed);
    int     e;
    longint acc, sum, gp, gi, gd;
    gp = kp;
    gi = ki;
    gd = kd;
    e = int'(held_cm) - int'(danger_cm);
    // Leak: drop the integral on zero error or when far outside the band
    if (e == 0 || e > int'(danger_cm)) integ = 0;
    acc = longint'(integ) + longint'(e) * 65536;
    if (acc > ACC_HI) acc = ACC_HI;
    if (acc < ACC_LO) acc = ACC_LO;
    integ = int'((acc * gi) >>> 16);
    sum = longint'(e) * gp + longint'(e - prev_err) * gd + longint'(integ);
    prev_err = e;
    speed = sum >>> 8;
    if (speed > SPEED_HI) speed = SPEED_HI;
    if (speed < SPEED_LO) speed = SPEED_LO;
    return (speed > MAX_DRIVE * 256) ? longint'(MAX_DRIVE * 256) : speed;
  endfunction

  function automatic pass_result_t predict_pass(input logic echo_ok, input logic [15:0] ticks,
                                                input logic [31:0] now, input logic [7:0] pick);
    pass_result_t r;
    logic [15:0]  cm;
    logic [31:0]  elapsed;
    longint       clamped, speed;
    r = '0;
    speed = 0;
    // Distance filter: average each pair of in-range readings
    if (echo_ok) begin
      cm = ticks / 16'(TICKS_PER_CM);
      if (cm <= MAX_CM_W && cm >= MIN_CM_W) begin
        pair_sum = pair_sum + cm[8:0];
        if (pair_half) begin
          held_cm   = pair_sum[8:1];
          pair_sum  = '0;
          pair_half = 1'b0;
        end else begin
          pair_half = 1'b1;
        end
      end
    end
    if (now - last_step >= {16'd0, interval_ms}) begin
      elapsed   = now - mode_start;
      last_step = now;
      case (mode_q)
        MODE_MOVE: begin
          clamped = pid_drive(speed);
          r.spd_v = 1'b1;
          if (held_cm <= danger_cm) begin
            mode_start = now;
            reported   = 1'b0;
            mode_q     = MODE_STOP;
          end else begin
            r.motor = MOTOR_FWD;
            r.drive = clamped[23:0];
            if (!reported) begin
              r.rep_v  = 1'b1;
              r.rep_c  = REP_FWD;
              reported = 1'b1;
            end
          end
        end
        MODE_STOP: begin
          r.motor = MOTOR_STOP;
          if (!reported) begin
            r.rep_v  = 1'b1;
            r.rep_c  = REP_STOP;
            reported = 1'b1;
          end
          if (elapsed >= {16'd0, stop_hold_ms}) begin
            mode_start = now;
            reported   = 1'b0;
            mode_q     = MODE_BACK;
          end
        end
        MODE_BACK: begin
          r.motor = MOTOR_BACK;
          if (!reported) begin
            r.rep_v  = 1'b1;
            r.rep_c  = REP_BACK;
            reported = 1'b1;
          end
          if (elapsed >= {16'd0, back_hold_ms}) begin
            mode_start = now;
            go_right   = (int'(pick) % TURN_SPAN) != 0;
            reported   = 1'b0;
            mode_q     = MODE_TURN;
          end
        end
        MODE_TURN: begin
          // Obstacle while turning: back to stop, keep start time and report flag
          if (held_cm <= danger_cm) begin
            mode_q = MODE_STOP;
          end else begin
            r.motor = go_right ? MOTOR_RIGHT : MOTOR_LEFT;
            if (!reported) begin
              r.rep_v  = 1'b1;
              r.rep_c  = go_right ? REP_RIGHT : REP_LEFT;
              reported = 1'b1;
            end
            if (elapsed >= {16'd0, turn_hold_ms}) begin
              mode_start = now;
              reported   = 1'b0;
              mode_q     = MODE_INIT;
            end
          end
        end
        default: mode_q = MODE_MOVE;
      endcase
    end
    r.speed = speed[23:0];
    r.mode  = mode_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    pass_result_t got, want;
    if (rst) begin
      danger_cm    = DANGER_RST;
      interval_ms  = INTERVAL_RST;
      stop_hold_ms = STOP_RST;
      back_hold_ms = BACK_RST;
      turn_hold_ms = TURN_RST;
      kp           = GAIN_P_RST;
      ki           = GAIN_I_RST;
      kd           = GAIN_D_RST;
      mode_q       = MODE_INIT;
      last_step    = '0;
      mode_start   = '0;
      reported     = 1'b0;
      go_right     = 1'b0;
      held_cm      = '0;
      pair_sum     = '0;
      pair_half    = 1'b0;
      integ        = 0;
      prev_err     = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DANGER:   danger_cm    = cfg_data[7:0];
          REG_INTERVAL: interval_ms  = cfg_data;
          REG_STOP:     stop_hold_ms = cfg_data;
          REG_BACK:     back_hold_ms = cfg_data;
          REG_TURN:     turn_hold_ms = cfg_data;
          REG_GAIN_P:   kp           = cfg_data;
          REG_GAIN_I:   ki           = cfg_data;
          REG_GAIN_D:   kd           = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(predict_pass(s_axis_tuser[0], s_axis_tdata[15:0],
                                          s_axis_tdata[47:16], s_axis_tdata[55:48]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.motor = motor_t'(m_axis_tdata[2:0]);
        got.drive = m_axis_tdata[26:3];
        got.rep_c = m_axis_tdata[29:27];
        got.speed = m_axis_tdata[53:30];
        got.mode  = mode_t'(m_axis_tdata[56:54]);
        got.rep_v = m_axis_tuser[0];
        got.spd_v = m_axis_tuser[1];
        if (expected_q.size() == 0) begin
          $error("result transfer with no prediction waiting");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("motor_cmd", 24'(want.motor), 24'(got.motor));
          check_field("drive", want.drive, got.drive);
          check_field("report_valid", 24'(want.rep_v), 24'(got.rep_v));
          check_field("report_code", 24'(want.rep_c), 24'(got.rep_c));
          check_field("speed_valid", 24'(want.spd_v), 24'(got.spd_v));
          check_field("speed_value", want.speed, got.speed);
          check_field("mode", 24'(want.mode), 24'(got.mode));
          if (m_axis_tdata[63:57] !== '0) begin
            $error("tdata fill: expected 0, actual %0d", m_axis_tdata[63:57]);
            fail_count++;
          end
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

FILE: bench/tb_obstacle_avoid_sequencer_pid_top.sv
// Testbench top for the obstacle avoidance sequencer: stimulus, register phases and verdict.
module tb_obstacle_avoid_sequencer_pid_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ova_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // echo_ticks[15:0], now_ms[47:16], turn_pick[55:48]
  logic [0:0]  s_axis_tuser = '0;  // echo_valid[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [63:0] m_axis_tdata;       // motor_cmd[2:0], drive[26:3], report_code[29:27],
                                   // speed_value[53:30], mode[56:54], zero fill
  logic [1:0]  m_axis_tuser;       // report_valid[0], speed_valid[1]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int outstanding;

  // Stimulus-side view of the world: current millisecond time, danger setting, obstacle
  logic [31:0] sim_ms = '0;
  logic [7:0]  danger_set = DANGER_RST;
  bit          near_obstacle = 1'b0;
  // While set, neither side idles
  bit          calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  obstacle_avoid_sequencer_pid_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  ova_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // Result side: stall at random about 13 percent of the time, never while calm
  always @(negedge clk) m_axis_tready <= calm || ($urandom_range(0, 99) >= 13);

  // Offer one pass item. Idle at random first, then hold tvalid until the transfer.
  // Leave tvalid high on return so back-to-back items need no drop in between.
  task automatic send_item(input logic echo_ok, input logic [15:0] ticks,
                           input logic [31:0] now, input logic [7:0] pick);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pick, now, ticks};
    s_axis_tuser  <= echo_ok;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop tvalid and wait for every predicted result, then let the pipe drain.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write all eight registers; only call with the block idle
  task automatic configure(input logic [15:0] danger, input logic [15:0] interval,
                           input logic [15:0] stop_hold, input logic [15:0] back_hold,
                           input logic [15:0] turn_hold, input logic [15:0] gp,
                           input logic [15:0] gi, input logic [15:0] gd);
    write_reg(REG_DANGER, danger);
    write_reg(REG_INTERVAL, interval);
    write_reg(REG_STOP, stop_hold);
    write_reg(REG_BACK, back_hold);
    write_reg(REG_TURN, turn_hold);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    danger_set = danger[7:0];
  endtask

  // Random traffic. Most items are a plausible drive: time moves forward a little and
  // echoes cluster around an obstacle that is either near (at or under the danger
  // distance) or far, flipping now and then so the mode machine runs its full loop.
  // The rest is noise: raw echo widths and time jumps in either direction.
  task automatic run_traffic(input int count, input int max_step);
    logic [15:0] ticks;
    logic        echo_ok;
    logic [7:0]  pick;
    int          cm;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 29) == 0) near_obstacle = !near_obstacle;
      pick = 8'($urandom());
      if ($urandom_range(0, 99) < 85) begin
        sim_ms  = sim_ms + $urandom_range(0, max_step);
        echo_ok = $urandom_range(0, 99) < 70;
        if (near_obstacle)
          cm = (danger_set >= MIN_CM) ?
               $urandom_range(MIN_CM, (danger_set > MAX_CM) ? MAX_CM : danger_set) : MIN_CM;
        else
          cm = (danger_set < MAX_CM) ? $urandom_range(danger_set + 1, MAX_CM) : MAX_CM;
        ticks = 16'(cm * TICKS_PER_CM + $urandom_range(0, TICKS_PER_CM - 1));
      end else begin
        echo_ok = $urandom_range(0, 1);
        ticks   = 16'($urandom());
        case ($urandom_range(0, 3))
          0:       sim_ms = $urandom();
          1:       sim_ms = sim_ms - $urandom_range(0, 200);
          default: sim_ms = sim_ms + $urandom_range(0, max_step);
        endcase
      end
      send_item(echo_ok, ticks, sim_ms, pick);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Directed pass with the reset register values. Walk the distance filter edges
    // (below minimum, minimum, maximum, over maximum, raw full-scale width), then one
    // full lap: init, move, stop, back, turn to the right, init, and a time wrap.
    send_item(1'b1, 16'd0,     32'd0,    8'd0);
    send_item(1'b1, 16'd115,   32'd10,   8'd0);
    send_item(1'b1, 16'hFFFF,  32'd20,   8'hFF);
    send_item(1'b1, 16'd11658, 32'd30,   8'd0);
    send_item(1'b1, 16'd116,   32'd40,   8'd0);
    send_item(1'b1, 16'd11600, 32'd50,   8'd0);
    send_item(1'b0, 16'd0,     32'd100,  8'd0);
    send_item(1'b0, 16'd0,     32'd150,  8'd0);
    send_item(1'b1, 16'd290,   32'd160,  8'd0);
    send_item(1'b1, 16'd290,   32'd170,  8'd0);
    send_item(1'b0, 16'd0,     32'd200,  8'd0);
    send_item(1'b0, 16'd0,     32'd250,  8'd0);
    send_item(1'b0, 16'd0,     32'd1250, 8'd0);
    send_item(1'b0, 16'd0,     32'd1300, 8'd0);
    send_item(1'b0, 16'd0,     32'd3300, 8'd1);
    send_item(1'b1, 16'd5800,  32'd3310, 8'd0);
    send_item(1'b1, 16'd5800,  32'd3320, 8'd0);
    send_item(1'b0, 16'd0,     32'd3350, 8'd0);
    send_item(1'b0, 16'd0,     32'd3400, 8'd0);
    send_item(1'b0, 16'd0,     32'd4400, 8'd0);
    send_item(1'b0, 16'd0,     32'd4450, 8'd0);
    send_item(1'b0, 16'd0,     32'hFFFF_FFF0, 8'd0);
    send_item(1'b0, 16'd0,     32'h0000_0020, 8'd0);
    send_item(1'b0, 16'd0,     32'h0000_0022, 8'd0);
    sim_ms = 32'h0000_0040;
    // Hold off until every directed result is back
    settle();

    // Short timings so the loop turns over often; start with a stretch of no idling
    configure(16'd20, 16'd5, 16'd30, 16'd40, 16'd30, GAIN_P_RST, GAIN_I_RST, GAIN_D_RST);
    calm = 1'b1;
    run_traffic(150, 12);
    calm = 1'b0;
    run_traffic(150, 12);
    settle();

    // Low extremes for distance and timing, a step on every pass, full-scale gains
    configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(200, 3);
    settle();

    // High extremes with zero gains; advance time in big leaps
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    run_traffic(150, 40000);
    settle();

    // Wide band so the integral winds up and saturates; cross the 32-bit time wrap
    configure(16'd100, 16'd1, 16'd10, 16'd10, 16'd10, 16'hFFFF, 16'hFFFF, 16'd0);
    sim_ms = 32'hFFFF_FE00;
    run_traffic(250, 4);
    settle();

    // Random register sets
    repeat (3) begin
      configure(16'($urandom()), 16'($urandom_range(0, 60)), 16'($urandom_range(0, 200)),
                16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                16'($urandom()), 16'($urandom()), 16'($urandom()));
      run_traffic(150, 30);
      settle();
    end

    // Back to the default register values
    configure(16'(DANGER_RST), INTERVAL_RST, STOP_RST, BACK_RST, TURN_RST,
              GAIN_P_RST, GAIN_I_RST, GAIN_D_RST);
    run_traffic(250, 120);

    // Drain with a bound, then wait out anything unexpected before the verdict
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    for (int wait_cycles = 0; wait_cycles < 1000 && outstanding != 0; wait_cycles++)
      @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
